// ----- design/tmr_pkg.sv -----
// Shared types and constants for the one-shot and periodic timer bank.
package tmr_pkg;

  localparam int unsigned NumTimersDef = 16;
  localparam int unsigned TimeBitsDef  = 48;
  localparam int unsigned MaskW        = 16;
  localparam int unsigned IndexW       = 4;
  localparam int unsigned DelayW       = 32;
  localparam int unsigned PeriodW      = 32;
  localparam int unsigned InTimeW      = 48;

  typedef enum logic [1:0] {
    ACT_ARM    = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_TICK   = 2'd3
  } tmr_action_e;

  typedef struct packed {
    tmr_action_e         action;
    logic [IndexW-1:0]   timer_index;
    logic [DelayW-1:0]   delay;
    logic [PeriodW-1:0]  repeat_interval;
    logic                one_shot;
    logic [InTimeW-1:0]  current_time;
    logic                paused;
  } tmr_in_t;

  typedef struct packed {
    logic [MaskW-1:0] fired_mask;
    logic             is_armed;
  } tmr_out_t;

  typedef struct packed {
    logic fire;
    logic armed_hit;
  } tmr_flags_t;

endpackage

// ----- design/one_shot_periodic_timer_bank_top.sv -----
// Top level of the timer bank: command control, ring of timer cells and result register.
//
// Usage: drive item_i and raise start; the item transfers at the rising edge where start
// is high and busy is low. Actions are arm, cancel, query and time tick.
// Every item takes one sweep of the timer ring: the timers rotate past the update unit
// at the ring head, one timer per cycle, and return to their home cells at the end of
// the sweep. The result appears on result_o with done_o high for exactly one
// cycle, right after the sweep; busy drops at the same edge, so the next item can
// transfer in the done cycle. No new item is taken while a sweep is running, since
// the single update unit is shared by all cells.
// Every item gives exactly one result: fired_mask on a tick, is_armed on a query, and
// zeros otherwise. The receiver cannot stall; a result is valid only in its done cycle.
// Reset clears all timers to disarmed, one-shot, due time and period zero, and leaves
// the block idle with no result pending.
module one_shot_periodic_timer_bank_top import tmr_pkg::*; #(
  parameter int unsigned NUM_TIMERS = NumTimersDef,
  parameter int unsigned TIME_BITS  = TimeBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  tmr_in_t  item_i,
  output logic     done_o,
  output tmr_out_t result_o
);

  localparam int unsigned SlotW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_SWEEP = 2'b10
  } state_e;

  state_e state_q, state_d;
  tmr_in_t cmd_q;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [MaskW-1:0] mask_q, mask_d;
  logic armed_hit_q, armed_hit_d;
  logic done_q, done_d;
  logic accept;
  logic shift;
  logic last;

  logic [TIME_BITS-1:0] due_w    [NUM_TIMERS];
  logic [PeriodW-1:0]   period_w [NUM_TIMERS];
  logic                 stop_w   [NUM_TIMERS];
  logic                 armed_w  [NUM_TIMERS];

  logic [TIME_BITS-1:0] due_upd;
  logic [PeriodW-1:0]   period_upd;
  logic                 stop_upd;
  logic                 armed_upd;
  tmr_flags_t           flags;

  assign accept = start && (state_q == ST_IDLE);
  assign shift  = (state_q == ST_SWEEP);
  assign last   = (slot_q == SlotW'(NUM_TIMERS - 1));

  tmr_unit #(
    .TIME_BITS(TIME_BITS),
    .SLOT_W   (SlotW)
  ) u_unit (
    .cmd_i   (cmd_q),
    .slot_i  (slot_q),
    .due_i   (due_w[0]),
    .period_i(period_w[0]),
    .stop_i  (stop_w[0]),
    .armed_i (armed_w[0]),
    .due_o   (due_upd),
    .period_o(period_upd),
    .stop_o  (stop_upd),
    .armed_o (armed_upd),
    .flags_o (flags)
  );

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    if (i == NUM_TIMERS - 1) begin : g_tail
      tmr_cell #(.TIME_BITS(TIME_BITS)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .due_i   (due_upd),
        .period_i(period_upd),
        .stop_i  (stop_upd),
        .armed_i (armed_upd),
        .due_o   (due_w[i]),
        .period_o(period_w[i]),
        .stop_o  (stop_w[i]),
        .armed_o (armed_w[i])
      );
    end else begin : g_body
      tmr_cell #(.TIME_BITS(TIME_BITS)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .due_i   (due_w[i+1]),
        .period_i(period_w[i+1]),
        .stop_i  (stop_w[i+1]),
        .armed_i (armed_w[i+1]),
        .due_o   (due_w[i]),
        .period_o(period_w[i]),
        .stop_o  (stop_w[i]),
        .armed_o (armed_w[i])
      );
    end
  end

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    mask_d      = mask_q;
    armed_hit_d = armed_hit_q;
    done_d      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d     = ST_SWEEP;
          slot_d      = '0;
          mask_d      = '0;
          armed_hit_d = 1'b0;
        end
      end
      ST_SWEEP: begin
        mask_d      = mask_q | (MaskW'(flags.fire) << slot_q);
        armed_hit_d = armed_hit_q | flags.armed_hit;
        if (last) begin
          state_d = ST_IDLE;
          slot_d  = '0;
          done_d  = 1'b1;
        end else begin
          slot_d = slot_q + SlotW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
        slot_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      mask_q      <= '0;
      armed_hit_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      mask_q      <= mask_d;
      armed_hit_q <= armed_hit_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= item_i;
    end
  end

  assign busy                = (state_q != ST_IDLE);
  assign done_o              = done_q;
  assign result_o.fired_mask = mask_q;
  assign result_o.is_armed   = armed_hit_q;

  a_done_ends_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("sweep ended without a result");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && (slot_q == '0))
    else $error("accepted transfer did not start a sweep");

  a_mask_tick_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.fired_mask != '0) |-> (cmd_q.action == ACT_TICK))
    else $error("fired mask set on a non-tick item");

  a_armed_query_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.is_armed |-> (cmd_q.action == ACT_QUERY))
    else $error("armed flag set on a non-query item");

endmodule

// ----- design/tmr_cell.sv -----
// One timer cell of the ring: holds a timer and takes its neighbor's timer on a shift.
module tmr_cell import tmr_pkg::*; #(
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  logic [TIME_BITS-1:0] due_i,
  input  logic [PeriodW-1:0]   period_i,
  input  logic                 stop_i,
  input  logic                 armed_i,
  output logic [TIME_BITS-1:0] due_o,
  output logic [PeriodW-1:0]   period_o,
  output logic                 stop_o,
  output logic                 armed_o
);

  logic [TIME_BITS-1:0] due_q;
  logic [PeriodW-1:0]   period_q;
  logic                 stop_q;
  logic                 armed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_q    <= '0;
      period_q <= '0;
      stop_q   <= 1'b1;
      armed_q  <= 1'b0;
    end else if (shift_i) begin
      due_q    <= due_i;
      period_q <= period_i;
      stop_q   <= stop_i;
      armed_q  <= armed_i;
    end
  end

  assign due_o    = due_q;
  assign period_o = period_q;
  assign stop_o   = stop_q;
  assign armed_o  = armed_q;

endmodule

// ----- design/tmr_unit.sv -----
// Update unit at the ring head: applies the current command to one timer.
module tmr_unit import tmr_pkg::*; #(
  parameter int unsigned TIME_BITS = TimeBitsDef,
  parameter int unsigned SLOT_W    = 4
) (
  input  tmr_in_t              cmd_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic [TIME_BITS-1:0] due_i,
  input  logic [PeriodW-1:0]   period_i,
  input  logic                 stop_i,
  input  logic                 armed_i,
  output logic [TIME_BITS-1:0] due_o,
  output logic [PeriodW-1:0]   period_o,
  output logic                 stop_o,
  output logic                 armed_o,
  output tmr_flags_t           flags_o
);

  localparam int unsigned SumW = ((TIME_BITS > DelayW) ? TIME_BITS : DelayW) + 1;
  localparam int unsigned CmpW = (SLOT_W > IndexW) ? SLOT_W : IndexW;
  localparam logic [TIME_BITS-1:0] TimeMax = {TIME_BITS{1'b1}};

  logic [TIME_BITS-1:0] now;
  logic                 hit;
  logic                 is_due;
  logic [SumW-1:0]      op_a;
  logic [SumW-1:0]      op_b;
  logic [SumW-1:0]      sum;
  logic [TIME_BITS-1:0] sum_sat;

  assign now    = TIME_BITS'(cmd_i.current_time);
  assign hit    = (CmpW'(cmd_i.timer_index) == CmpW'(slot_i));
  assign is_due = armed_i && (due_i <= now);

  assign op_a    = (cmd_i.action == ACT_ARM) ? SumW'(now) : SumW'(due_i);
  assign op_b    = (cmd_i.action == ACT_ARM) ? SumW'(cmd_i.delay) : SumW'(period_i);
  assign sum     = op_a + op_b;
  assign sum_sat = (sum > SumW'(TimeMax)) ? TimeMax : TIME_BITS'(sum);

  always_comb begin
    due_o             = due_i;
    period_o          = period_i;
    stop_o            = stop_i;
    armed_o           = armed_i;
    flags_o.fire      = 1'b0;
    flags_o.armed_hit = 1'b0;
    case (cmd_i.action)
      ACT_ARM: begin
        if (hit) begin
          due_o    = sum_sat;
          period_o = cmd_i.repeat_interval;
          stop_o   = cmd_i.one_shot;
          armed_o  = 1'b1;
        end
      end
      ACT_CANCEL: begin
        if (hit) begin
          armed_o = 1'b0;
        end
      end
      ACT_QUERY: begin
        flags_o.armed_hit = hit && armed_i;
      end
      ACT_TICK: begin
        if (is_due) begin
          flags_o.fire = !cmd_i.paused;
          if (stop_i) begin
            armed_o = 1'b0;
          end else begin
            due_o = sum_sat;
          end
        end
      end
      default: begin
        armed_o = armed_i;
      end
    endcase
  end

endmodule
